[src/doq_pkg.sv]
// Shared types and constants for the drop-oldest queue with burst drain.
// No dependencies; imported by the top level and its port checker.
package doq_pkg;

    // Field widths fixed by the stream format
    localparam int VALUE_W   = 32;
    localparam int BURST_W   = 5;
    localparam int CAP_W     = 5;
    localparam int S_TDATA_W = 40;

    // Default storage depth and register reset value
    localparam int               DEPTH_DEFAULT = 16;
    localparam logic [CAP_W-1:0] CAP_RESET     = 5'd16;

    // Most results one drain request may produce
    localparam logic [BURST_W-1:0] RESULT_LIMIT = 5'd16;

    // Request opcodes carried on s_tuser
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DRAIN   = 1'b1;

    // Sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } doq_state_t;

endpackage

[src/drop_oldest_queue_burst_drain.sv]
// Drop-oldest circular queue with burst drain, built around one entry memory.
// Depends on doq_pkg (widths, opcodes, sequencer state type).
//
// Channel   Dir  Signals                             Contents
// s_        in   s_tvalid s_tready s_tdata s_tuser   one request (enqueue or drain)
// m_        out  m_tvalid m_tready m_tdata m_tlast   one result per removed entry
//                m_tuser
// cfg_      in   cfg_valid cfg_ready cfg_data        capacity register write
//
// An enqueue writes the entry memory directly. A drain of n entries is latched,
// then reads one entry at a time through the single memory read port; a drain
// that removes nothing loads an empty result. Read data passes a one-entry
// stage and the output register, so results leave at one per cycle when m_tready
// stays high. Reset clears head, count and sequencer and sets capacity to 16;
// the entry memory is not cleared. A stalled m_ side holds reads and requests.
module drop_oldest_queue_burst_drain
    import doq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // request channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] item_value, [36:32] burst_count
    input  logic                 s_tuser,   // [0] opcode
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [VALUE_W-1:0]   m_tdata,   // [31:0] out_value
    output logic                 m_tlast,   // burst_last
    output logic                 m_tuser,   // [0] empty_burst
    // capacity register write
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CAP_W-1:0]     cfg_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;

    // Control and payload registers
    doq_state_t           state_reg, state_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [BURST_W-1:0]   rem_reg, rem_next;
    logic [CAP_W-1:0]     cap_reg;

    logic [VALUE_W-1:0]   entry_mem_reg [DEPTH];
    logic [VALUE_W-1:0]   rd_data_reg;
    logic                 rd_valid_reg, rd_valid_next;
    logic                 rd_last_reg, rd_last_next;
    logic                 rd_empty_reg, rd_empty_next;

    logic                 out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]   out_value_reg;
    logic                 out_last_reg;
    logic                 out_empty_reg;

    // Datapath helpers
    logic                 s_acc;
    logic                 out_load;
    logic                 slot_free;
    logic                 rd_en;
    logic                 wr_en;
    logic                 empty_load;
    logic                 drain_load;
    logic [AW-1:0]        head_inc;
    logic [LW-1:0]        cap_eff;
    logic                 drop;
    logic [AW-1:0]        head_enq;
    logic [CW-1:0]        count_kept;
    logic [AW:0]          tail_sum;
    logic [AW-1:0]        tail_addr;
    logic [BURST_W-1:0]   k_sat;
    logic [BURST_W-1:0]   n_take;

    // Handshakes
    assign out_load  = rd_valid_reg && (!out_valid_reg || m_tready);
    assign slot_free = !rd_valid_reg || out_load;
    assign s_tready  = (state_reg == ST_IDLE) && slot_free;
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_empty_reg;

    // Pointer arithmetic: head wrap, drop decision and tail address
    always_comb begin
        head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;

        if (cap_reg == '0) begin
            cap_eff = LW'(1);
        end else if (LW'(cap_reg) > LW'(DEPTH)) begin
            cap_eff = LW'(DEPTH);
        end else begin
            cap_eff = LW'(cap_reg);
        end

        drop       = (LW'(count_reg) >= cap_eff) && (count_reg != '0);
        head_enq   = drop ? head_inc : head_reg;
        count_kept = drop ? count_reg - 1'b1 : count_reg;
        tail_sum   = {1'b0, head_enq} + (AW + 1)'(count_kept);
        tail_addr  = (tail_sum >= (AW + 1)'(DEPTH)) ? AW'(tail_sum - (AW + 1)'(DEPTH))
                                                    : AW'(tail_sum);

        k_sat  = (s_tdata[VALUE_W +: BURST_W] > RESULT_LIMIT) ? RESULT_LIMIT
                                                              : s_tdata[VALUE_W +: BURST_W];
        n_take = (LW'(k_sat) < LW'(count_reg)) ? k_sat : BURST_W'(count_reg);
    end

    // Next state of the drain sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && (s_tuser == OP_DRAIN) && (n_take != '0)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (slot_free && (rem_reg == BURST_W'(1))) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: memory strobes and stage loads
    always_comb begin
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        empty_load = 1'b0;
        drain_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                wr_en      = s_acc && (s_tuser == OP_ENQUEUE);
                empty_load = s_acc && (s_tuser == OP_DRAIN) && (n_take == '0);
                drain_load = s_acc && (s_tuser == OP_DRAIN) && (n_take != '0);
            end
            ST_DRAIN: begin
                rd_en = slot_free;
            end
            default: ;
        endcase
    end

    // Next values of pointers, count and pipeline stages
    always_comb begin
        head_next      = head_reg;
        count_next     = count_reg;
        rem_next       = rem_reg;
        rd_valid_next  = rd_valid_reg && !out_load;
        rd_last_next   = rd_last_reg;
        rd_empty_next  = rd_empty_reg;
        out_valid_next = out_load || (out_valid_reg && !m_tready);

        priority if (wr_en) begin
            head_next  = head_enq;
            count_next = count_kept + 1'b1;
        end else if (rd_en) begin
            head_next     = head_inc;
            count_next    = count_reg - 1'b1;
            rem_next      = rem_reg - 1'b1;
            rd_valid_next = 1'b1;
            rd_last_next  = (rem_reg == BURST_W'(1));
            rd_empty_next = 1'b0;
        end else if (empty_load) begin
            rd_valid_next = 1'b1;
            rd_last_next  = 1'b1;
            rd_empty_next = 1'b1;
        end else if (drain_load) begin
            rem_next = n_take;
        end else begin
            rem_next = rem_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            rem_reg       <= '0;
            cap_reg       <= CAP_RESET;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_data;
            end
        end
    end

    // Entry memory: write on enqueue, registered read on drain. Writes happen
    // only in idle and reads only while draining, so no entry is written and
    // read in the same cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem_reg[tail_addr] <= s_tdata[VALUE_W-1:0];
        end
        if (rd_en) begin
            rd_data_reg <= entry_mem_reg[head_reg];
        end
    end

    // Stage flags and output payload
    always_ff @(posedge aclk) begin
        rd_last_reg  <= rd_last_next;
        rd_empty_reg <= rd_empty_next;
        if (out_load) begin
            out_value_reg <= rd_empty_reg ? '0 : rd_data_reg;
            out_last_reg  <= rd_last_reg;
            out_empty_reg <= rd_empty_reg;
        end
    end

endmodule

[src/doq_checker.sv]
// Port-level checker for the drop-oldest queue, bound to the top level.
// Depends on doq_pkg for port widths.
module doq_checker
    import doq_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [VALUE_W-1:0]   m_tdata,
    input logic                 m_tlast,
    input logic                 m_tuser,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [CAP_W-1:0]     cfg_data
);

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("stalled result changed");

    // An empty drain result is a single zero-valued last result
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == '0))
        else $error("empty result malformed");

    // A burst in progress never yields an empty result next
    a_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> !(m_tvalid && m_tuser))
        else $error("empty result inside a burst");

    // Capacity writes are never refused
    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("capacity write refused");

endmodule

bind drop_oldest_queue_burst_drain doq_checker u_doq_checker (.*);

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for drop_oldest_queue_burst_drain: random and directed requests
// checked against a behavioral queue model. Depends on doq_pkg and the top-level RTL.
module tb_top
    import doq_pkg::*;
();

    localparam int       QDEPTH      = DEPTH_DEFAULT;
    localparam int       CYCLE_LIMIT = 1000000;
    localparam int       PAD_W       = S_TDATA_W - VALUE_W - BURST_W;

    typedef struct {
        logic                 op;
        logic [VALUE_W-1:0]   value;
        logic [BURST_W-1:0]   burst;
    } queue_req_t;

    typedef struct {
        logic [VALUE_W-1:0]   value;
        logic                 last;
        logic                 empty;
    } drain_result_t;

    // clock, reset and DUT ports; every input known from time zero
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // [31:0] item_value, [36:32] burst_count
    logic                 s_tuser   = 1'b0; // [0] opcode
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [VALUE_W-1:0]   m_tdata;          // [31:0] out_value
    logic                 m_tlast;          // burst_last
    logic                 m_tuser;          // [0] empty_burst
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CAP_W-1:0]     cfg_data  = '0;

    // stimulus and scoreboard state
    queue_req_t           pending_reqs[$];
    drain_result_t        due_results[$];
    drain_result_t        want;
    logic                 req_taken = 1'b0;
    logic                 cfg_taken = 1'b0;
    int unsigned          send_idle_pct = 0;
    int unsigned          recv_idle_pct = 0;
    int                   error_count = 0;
    int                   req_count = 0;
    int                   result_count = 0;
    int                   cfg_count = 0;
    int                   cycle_count = 0;

    // queue model
    logic [VALUE_W-1:0]   model_store[QDEPTH];
    int unsigned          model_head = 0;
    int unsigned          model_count = 0;
    logic [CAP_W-1:0]     model_cap = CAP_RESET;

    drop_oldest_queue_burst_drain #(
        .DEPTH (QDEPTH)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Clamp the capacity register into 1..DEPTH.
    function automatic int unsigned held_limit(input logic [CAP_W-1:0] cap);
        int unsigned c;
        c = cap;
        if (c < 1) c = 1;
        if (c > QDEPTH) c = QDEPTH;
        return c;
    endfunction

    // Append one expected result to the scoreboard.
    task automatic expect_result(input drain_result_t r);
        due_results.insert(due_results.size(), r);
    endtask

    // Append one request to the stimulus list.
    task automatic queue_request(input queue_req_t req);
        pending_reqs.insert(pending_reqs.size(), req);
    endtask

    // Advance the queue model by one request and queue the results it causes.
    task automatic advance_queue_model(input queue_req_t req);
        int unsigned k;
        int unsigned n;
        drain_result_t r;
        if (req.op == OP_ENQUEUE) begin
            // drop the head once when at or above capacity, then append
            if (model_count >= held_limit(model_cap) && model_count > 0) begin
                model_head  = (model_head + 1) % QDEPTH;
                model_count = model_count - 1;
            end
            if (model_count < QDEPTH) begin
                model_store[(model_head + model_count) % QDEPTH] = req.value;
                model_count = model_count + 1;
            end
        end else begin
            k = req.burst;
            if (k > RESULT_LIMIT) k = RESULT_LIMIT;
            n = (k < model_count) ? k : model_count;
            if (n == 0) begin
                r.value = '0;
                r.last  = 1'b1;
                r.empty = 1'b1;
                expect_result(r);
            end
            for (int unsigned i = 0; i < n; i++) begin
                r.value = model_store[model_head];
                r.last  = (i + 1 == n);
                r.empty = 1'b0;
                model_head  = (model_head + 1) % QDEPTH;
                model_count = model_count - 1;
                expect_result(r);
            end
        end
    endtask

    // Drive requests and receiver stalls at the falling edge.
    always @(negedge aclk) begin
        if (aresetn) begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (!s_tvalid || req_taken) begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{PAD_W{1'b0}}, pending_reqs[0].burst, pending_reqs[0].value};
                    s_tuser  <= pending_reqs[0].op;
                    pending_reqs.delete(0);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sample handshakes at the rising edge: check results, update the model.
    always @(posedge aclk) begin
        if (aresetn) begin
            req_taken <= s_tvalid && s_tready;
            cfg_taken <= cfg_valid && cfg_ready;
            if (m_tvalid && m_tready) begin
                result_count++;
                if (due_results.size() == 0) begin
                    $error("unexpected result: out_value %0h last %0b empty %0b",
                           m_tdata, m_tlast, m_tuser);
                    error_count++;
                end else begin
                    want = due_results[0];
                    due_results.delete(0);
                    if (m_tdata !== want.value) begin
                        $error("out_value mismatch: expected %0h, actual %0h",
                               want.value, m_tdata);
                        error_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("burst_last mismatch: expected %0b, actual %0b",
                               want.last, m_tlast);
                        error_count++;
                    end
                    if (m_tuser !== want.empty) begin
                        $error("empty_burst mismatch: expected %0b, actual %0b",
                               want.empty, m_tuser);
                        error_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                model_cap = cfg_data;
                cfg_count++;
            end
            if (s_tvalid && s_tready) begin
                req_count++;
                advance_queue_model('{op: s_tuser, value: s_tdata[VALUE_W-1:0],
                                      burst: s_tdata[VALUE_W +: BURST_W]});
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("drop_oldest_queue_burst_drain test failed");
            $finish;
        end
    end

    task automatic push_enqueue(input logic [VALUE_W-1:0] value);
        queue_req_t req;
        req.op    = OP_ENQUEUE;
        req.value = value;
        req.burst = BURST_W'($urandom);
        queue_request(req);
    endtask

    task automatic push_drain(input logic [BURST_W-1:0] burst);
        queue_req_t req;
        req.op    = OP_DRAIN;
        req.value = $urandom;
        req.burst = burst;
        queue_request(req);
    endtask

    // Pick a value, biased toward the extremes now and then.
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Queue runs of enqueues, each closed by a drain; a few back-to-back drains.
    task automatic push_random_traffic(input int n_items);
        int added;
        int run;
        int sel;
        added = 0;
        while (added < n_items) begin
            run = $urandom_range(0, 20);
            for (int i = 0; i < run && added < n_items; i++) begin
                push_enqueue(pick_value());
                added++;
            end
            sel = $urandom_range(0, 9);
            if (sel == 0) push_drain('0);
            else if (sel == 1) push_drain(BURST_W'($urandom_range(17, 31)));
            else push_drain(BURST_W'($urandom_range(1, 16)));
            added++;
            if ($urandom_range(0, 7) == 0) begin
                push_drain(BURST_W'($urandom_range(0, 31)));
                added++;
            end
        end
    endtask

    // Wait until every request is taken and every result has come back.
    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_reqs.size() != 0 || s_tvalid || due_results.size() != 0);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do @(negedge aclk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [CAP_W-1:0] phase_caps[8];
        phase_caps = '{5'd1, 5'd31, 5'd0, 5'd16, 5'd5, 5'd2, 5'd10, 5'd31};

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty drains, extreme values and zero and partial bursts
        push_drain(5'd5);
        push_enqueue(32'h8000_0000);
        push_enqueue(32'h7FFF_FFFF);
        push_enqueue(32'h0000_0000);
        push_enqueue(32'hFFFF_FFFF);
        push_enqueue(32'h5555_5555);
        push_enqueue(32'hAAAA_AAAA);
        push_drain(5'd0);
        push_drain(5'd2);
        wait_drained();

        // lower capacity below the held count, then drain with a saturating burst
        write_capacity(5'd2);
        push_enqueue(32'h0000_0007);
        push_drain(5'd31);
        push_enqueue(32'h0000_0001);
        push_enqueue(32'h0000_0002);
        push_enqueue(32'h0000_0003);
        push_drain(5'd16);
        wait_drained();

        // zero capacity holds a single entry
        write_capacity(5'd0);
        push_enqueue(32'h1234_5678);
        push_enqueue(32'h8765_4321);
        push_drain(5'd1);
        push_drain(5'd17);
        wait_drained();

        // random phases rotating through the idle modes
        for (int p = 0; p < 8; p++) begin
            write_capacity(phase_caps[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                1: begin send_idle_pct = 87; recv_idle_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_idle_pct = 87; end
                default: begin send_idle_pct = 33; recv_idle_pct = 33; end
            endcase
            push_random_traffic(58);
            wait_drained();
        end

        repeat (20) @(negedge aclk);
        $display("Ran %0d requests and %0d results across %0d capacity writes,",
                 req_count, result_count, cfg_count);
        $display("including empty and saturating drains and drop-oldest overflow.");
        if (error_count == 0 && due_results.size() == 0) begin
            $display("drop_oldest_queue_burst_drain test passed");
        end else begin
            $display("drop_oldest_queue_burst_drain test failed");
        end
        $finish;
    end

endmodule
